FILE: rtl/dtcf_pkg.sv
`timescale 1ns / 1ps
package dtcf_pkg;

  localparam int MAX_EXP_WIDTH  = 11;
  localparam int MAX_FRAC_WIDTH = 52;
  localparam int SIG_W  = 53;
  localparam int Q_W    = 54;
  localparam int EXP_W  = 14;
  localparam int DATA_W = 72;

  localparam logic [0:0] REG_EXP_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAC_WIDTH = 1'b1;

  // Decoded input: unbiased exponent of the value and weight of the sig lsb.
  typedef struct packed {
    logic                    sign;
    logic                    special;
    logic signed [EXP_W-1:0] x;
    logic signed [EXP_W-1:0] e;
    logic [SIG_W-1:0]        sig;
  } dec_t;

  // Shift plan for the significand.
  typedef struct packed {
    logic                    sign;
    logic                    special;
    logic signed [EXP_W-1:0] x;
    logic                    right;
    logic [5:0]              amt;
    logic [SIG_W-1:0]        sig;
  } aln_t;

  // Truncated significand with rounding bits.
  typedef struct packed {
    logic                    sign;
    logic                    special;
    logic signed [EXP_W-1:0] x;
    logic [Q_W-1:0]          q;
    logic                    guard;
    logic                    sticky;
  } shf_t;

  typedef struct packed {
    logic        overflow;
    logic [51:0] frac_field;
    logic [10:0] exp_field;
    logic        sign;
  } res_t;

endpackage

FILE: rtl/dtcf_decode.sv
`timescale 1ns / 1ps
module dtcf_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v_in,
  output logic               rdy_out,
  input  logic [63:0]        value_bits,
  output logic               v_out,
  input  logic               rdy_in,
  output dtcf_pkg::dec_t     d_out
);
  import dtcf_pkg::*;

  logic   v_r;
  dec_t   d_r, d_nxt;
  logic [10:0] dexp;
  logic [51:0] mant;
  logic [5:0]  p;

  assign dexp = value_bits[62:52];
  assign mant = value_bits[51:0];

  // Leading one position of a denormal mantissa.
  always_comb begin
    p = '0;
    for (int i = 0; i < 52; i++) begin
      if (mant[i]) p = 6'(i);
    end
  end

  always_comb begin
    d_nxt.sign    = value_bits[63];
    d_nxt.special = (dexp == 11'h7FF);
    if (dexp == '0) begin
      d_nxt.sig = {1'b0, mant};
      d_nxt.e   = -14'sd1074;
      d_nxt.x   = $signed({8'b0, p}) - 14'sd1074;
    end else begin
      d_nxt.sig = {1'b1, mant};
      d_nxt.e   = $signed({3'b0, dexp}) - 14'sd1075;
      d_nxt.x   = $signed({3'b0, dexp}) - 14'sd1023;
    end
  end

  assign rdy_out = !v_r || rdy_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_out) begin
      v_r <= v_in;
    end
    if (rdy_out && v_in) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;
endmodule

FILE: rtl/dtcf_align.sv
`timescale 1ns / 1ps
module dtcf_align (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         ew,
  input  logic [5:0]         fw,
  input  logic               v_in,
  output logic               rdy_out,
  input  dtcf_pkg::dec_t     d_in,
  output logic               v_out,
  input  logic               rdy_in,
  output dtcf_pkg::shf_t     s_out
);
  import dtcf_pkg::*;

  logic   v1_r, v2_r, rdy1;
  aln_t   a_r, a_nxt;
  shf_t   s_r, s_nxt;
  logic signed [EXP_W-1:0] min_x, xc, sh;
  logic [10:0]  bias;
  logic [SIG_W+63:0] wide;

  assign bias  = 11'((12'd1 << (ew - 4'd1)) - 12'd1);
  assign min_x = 14'sd1 - $signed({3'b0, bias});

  // Stage A: clamp into the denormal range and find the shift.
  always_comb begin
    xc = (d_in.x < min_x) ? min_x : d_in.x;
    sh = xc - $signed({8'b0, fw}) - d_in.e;
    a_nxt.sign    = d_in.sign;
    a_nxt.special = d_in.special;
    a_nxt.x       = xc;
    a_nxt.sig     = d_in.sig;
    a_nxt.right   = (sh > 14'sd0);
    if (sh > 14'sd63) begin
      a_nxt.amt = 6'd63;
    end else if (sh > 14'sd0) begin
      a_nxt.amt = sh[5:0];
    end else begin
      a_nxt.amt = 6'(-sh);
    end
  end

  // Stage B: barrel shift, collecting guard and sticky on the right.
  always_comb begin
    wide = {a_r.sig, 64'b0} >> a_r.amt;
    s_nxt.sign    = a_r.sign;
    s_nxt.special = a_r.special;
    s_nxt.x       = a_r.x;
    if (a_r.right) begin
      s_nxt.q      = {1'b0, wide[SIG_W+63:64]};
      s_nxt.guard  = wide[63];
      s_nxt.sticky = |wide[62:0];
    end else begin
      s_nxt.q      = Q_W'({1'b0, a_r.sig} << a_r.amt);
      s_nxt.guard  = 1'b0;
      s_nxt.sticky = 1'b0;
    end
  end

  assign rdy1    = !v2_r || rdy_in;
  assign rdy_out = !v1_r || rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy_out) v1_r <= v_in;
      if (rdy1)    v2_r <= v1_r;
    end
    if (rdy_out && v_in) a_r <= a_nxt;
    if (rdy1 && v1_r)    s_r <= s_nxt;
  end

  assign v_out = v2_r;
  assign s_out = s_r;
endmodule

FILE: rtl/dtcf_round.sv
`timescale 1ns / 1ps
module dtcf_round (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         ew,
  input  logic [5:0]         fw,
  input  logic               v_in,
  output logic               rdy_out,
  input  dtcf_pkg::shf_t     s_in,
  output logic               v_out,
  input  logic               rdy_in,
  output dtcf_pkg::res_t     r_out
);
  import dtcf_pkg::*;

  logic   v_r;
  res_t   r_r, r_nxt;
  logic [Q_W-1:0] qr, hidden, qf;
  logic [10:0]    bias, all_ones;
  logic signed [EXP_W-1:0] field;
  logic           norm, ovf;

  assign bias     = 11'((12'd1 << (ew - 4'd1)) - 12'd1);
  assign all_ones = 11'((12'd1 << ew) - 12'd1);
  assign hidden   = Q_W'(1) << fw;

  always_comb begin
    // Round to nearest, ties to even.
    qr    = s_in.q + Q_W'(s_in.guard && (s_in.sticky || s_in.q[0]));
    norm  = (qr >= hidden);
    field = '0;
    qf    = qr;
    if (norm) begin
      field = s_in.x + $signed({3'b0, bias});
      if (qr >= (hidden << 1)) begin
        field = field + 14'sd1;
        qf    = qr >> 1;
      end
      qf = qf - hidden;
    end
    ovf = s_in.special || (norm && field >= $signed({3'b0, all_ones}));
    r_nxt.sign     = s_in.sign;
    r_nxt.overflow = ovf;
    if (ovf) begin
      r_nxt.exp_field  = all_ones;
      r_nxt.frac_field = '0;
    end else begin
      r_nxt.exp_field  = field[10:0];
      r_nxt.frac_field = qf[51:0];
    end
  end

  assign rdy_out = !v_r || rdy_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_out) begin
      v_r <= v_in;
    end
    if (rdy_out && v_in) r_r <= r_nxt;
  end

  assign v_out = v_r;
  assign r_out = r_r;
endmodule

FILE: rtl/double_to_custom_float_unit.sv
`timescale 1ns / 1ps
// Channel | Dir | Fields (tdata from bit 0 up)
// in_     | in  | value_bits[63:0]
// out_    | out | sign, exp_field[11], frac_field[52], overflow, zero pad to 72
// cfg_    | in  | cfg_index 0 = exp_width, 1 = frac_width; cfg_data[5:0]
// One word is accepted every cycle while the output is not stalled; each word passes
// through the decode, shift-plan, barrel-shift and round registers.
// Reset sets exp_width to 8, frac_width to 23 and empties the pipeline.
// A stall at the output holds every full stage; a stage refills when it is empty
// or its successor moves, so no word is dropped or duplicated.
module double_to_custom_float_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // sign, exp_field, frac_field, overflow, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import dtcf_pkg::*;

  logic [3:0] exp_width_r;
  logic [5:0] frac_width_r;
  logic [3:0] ew;
  logic [5:0] fw;
  logic       v1, r1, v2, r2;
  dec_t       dec;
  shf_t       shf;
  res_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_width_r  <= 4'd8;
      frac_width_r <= 6'd23;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXP_WIDTH:  exp_width_r  <= cfg_data[3:0];
        REG_FRAC_WIDTH: frac_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ew = (exp_width_r < 4'd2) ? 4'd2 :
              (exp_width_r > 4'(MAX_EXP_WIDTH)) ? 4'(MAX_EXP_WIDTH) : exp_width_r;
  assign fw = (frac_width_r < 6'd1) ? 6'd1 :
              (frac_width_r > 6'(MAX_FRAC_WIDTH)) ? 6'(MAX_FRAC_WIDTH) : frac_width_r;

  dtcf_decode u_dec (
    .clk, .rst_n, .v_in(in_tvalid), .rdy_out(in_tready), .value_bits(in_tdata),
    .v_out(v1), .rdy_in(r1), .d_out(dec)
  );

  dtcf_align u_aln (
    .clk, .rst_n, .ew, .fw, .v_in(v1), .rdy_out(r1), .d_in(dec),
    .v_out(v2), .rdy_in(r2), .s_out(shf)
  );

  dtcf_round u_rnd (
    .clk, .rst_n, .ew, .fw, .v_in(v2), .rdy_out(r2), .s_in(shf),
    .v_out(out_tvalid), .rdy_in(out_tready), .r_out(res)
  );

  assign out_tdata = {7'b0, res.overflow, res.frac_field, res.exp_field, res.sign};

  a_ovf_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> out_tdata[63:12] == 52'b0)
    else $error("overflow result carries a nonzero fraction");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("pipeline blocks input while output is ready");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[64] |->
      out_tdata[11:1] != 11'((12'd1 << ew) - 12'd1))
    else $error("finite result uses the infinity exponent");
endmodule

FILE: sim/tb_double_to_custom_float_unit.sv
`timescale 1ns / 1ps
module tb_double_to_custom_float_unit;
  import dtcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // value_bits
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // sign, exp_field[11], frac_field[52], overflow, zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [5:0]  cfg_data;

  logic [3:0] cur_exp_w;
  logic [5:0] cur_frac_w;
  res_t       pending_q[$];
  int         error_count;
  int         in_idle_pct;
  int         out_idle_pct;
  int         hold_cycles;
  int         quiet_cycles = 0;

  double_to_custom_float_unit dut (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic res_t predict_minifloat(logic [63:0] bits);
    int          ew, fw, bias, all_ones, dexp, e, p, x, s, field;
    logic [63:0] sig, q, hidden, rem, half;
    bit          ovf;
    res_t        r;
    ew       = clamp_int(int'(cur_exp_w), 2, MAX_EXP_WIDTH);
    fw       = clamp_int(int'(cur_frac_w), 1, MAX_FRAC_WIDTH);
    bias     = (1 << (ew - 1)) - 1;
    all_ones = (1 << ew) - 1;
    r        = '0;
    r.sign   = bits[63];
    dexp     = int'(bits[62:52]);
    hidden   = 64'd1 << fw;
    ovf      = 1'b0;
    field    = 0;
    q        = '0;
    if (dexp == 2047) begin
      ovf = 1'b1;
    end else begin
      if (dexp == 0) begin
        sig = {12'b0, bits[51:0]};
        e   = -1074;
      end else begin
        sig = {11'b0, 1'b1, bits[51:0]};
        e   = dexp - 1075;
      end
      if (sig == 0) return r;
      p = 63;
      while (!sig[p]) p--;
      x = e + p;
      // Denormals share the smallest normal exponent.
      if (x < 1 - bias) x = 1 - bias;
      s = x - fw - e;
      if (s <= 0) begin
        q = sig << (-s);
      end else if (s > 60) begin
        q = '0;
      end else begin
        rem  = sig & ((64'd1 << s) - 1);
        half = 64'd1 << (s - 1);
        q    = sig >> s;
        if (rem > half || (rem == half && q[0])) q++;
      end
      if (q >= hidden) begin
        field = x + bias;
        if (q >= (hidden << 1)) begin
          q >>= 1;
          field++;
        end
        q -= hidden;
      end
      if (field >= all_ones) ovf = 1'b1;
    end
    if (ovf) begin
      r.exp_field = all_ones[10:0];
      r.overflow  = 1'b1;
    end else begin
      r.exp_field  = field[10:0];
      r.frac_field = q[51:0];
    end
    return r;
  endfunction

  // Most values land near the target's exponent range so that rounding,
  // denormals and overflow are all exercised; the rest is raw noise, infinities, NaNs and double denormals.
  function automatic logic [63:0] random_double();
    int          ew, fw, bias, lo, hi, k, sel;
    logic [51:0] mant;
    logic [10:0] dexp;
    ew   = clamp_int(int'(cur_exp_w), 2, MAX_EXP_WIDTH);
    fw   = clamp_int(int'(cur_frac_w), 1, MAX_FRAC_WIDTH);
    bias = (1 << (ew - 1)) - 1;
    sel  = $urandom_range(99);
    mant = 52'({$urandom, $urandom});
    if (sel < 8) return {$urandom, $urandom};
    if (sel < 11) return {1'($urandom), 11'h7FF, ($urandom_range(1) ? mant : 52'd0)};
    if (sel < 14) return {1'($urandom), 11'h000, mant >> $urandom_range(52)};
    lo   = clamp_int(1023 - bias - fw - 3, 1, 2046);
    hi   = clamp_int(1023 + bias + 1, 1, 2046);
    dexp = 11'($urandom_range(hi, lo));
    if (sel < 50) begin
      // Low bits set to an exact half or just off it.
      k    = $urandom_range(52, 1);
      mant = ((mant >> k) << k) | (52'd1 << (k - 1));
      if (sel < 30 && k > 1) mant = mant + 52'($urandom_range(1)) - 52'($urandom_range(1));
    end
    return {1'($urandom), dexp, mant};
  endfunction

  task automatic send_value(logic [63:0] v);
    in_tdata  <= v;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(predict_minifloat(v));
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [5:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_EXP_WIDTH) cur_exp_w = val[3:0];
    else cur_frac_w = val;
    @(posedge clk);
  endtask

  task automatic send_directed();
    send_value(64'h0000_0000_0000_0000);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h7FF0_0000_0000_0000);
    send_value(64'hFFF0_0000_0000_0000);
    send_value(64'h7FF8_0000_0000_0001);
    send_value(64'h3FF0_0000_0000_0000);
    send_value(64'hBFF8_0000_0000_0000);
    send_value(64'h7FEF_FFFF_FFFF_FFFF);
    send_value(64'h0000_0000_0000_0001);
    send_value(64'h000F_FFFF_FFFF_FFFF);
    send_value(64'h0010_0000_0000_0000);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'h3FF0_0000_1000_0000);
    send_value(64'h3FF0_0000_3000_0000);
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      1: begin in_idle_pct = 57; out_idle_pct = 0;  end
      2: begin in_idle_pct = 0;  out_idle_pct = 57; end
      default: begin in_idle_pct = 34; out_idle_pct = 34; end
    endcase
  endtask

  task automatic test_reset_format();
    set_idling(0);
    send_directed();
    drain();
  endtask

  task automatic test_width_settings();
    logic [3:0] ew_list[10] = '{2, 11, 0, 15, 5, 8, 3, 11, 2, 4};
    logic [5:0] fw_list[10] = '{1, 52, 0, 63, 10, 7, 2, 1, 52, 3};
    for (int i = 0; i < 10; i++) begin
      write_reg(REG_EXP_WIDTH, {2'b0, ew_list[i]});
      write_reg(REG_FRAC_WIDTH, fw_list[i]);
      set_idling(0);
      send_directed();
      set_idling(i);
      repeat (140) send_value(random_double());
      drain();
    end
  endtask

  task automatic test_output_hold_off();
    write_reg(REG_EXP_WIDTH, 6'd5);
    write_reg(REG_FRAC_WIDTH, 6'd10);
    set_idling(0);
    hold_cycles = 300;
    repeat (150) send_value(random_double());
    drain();
  endtask

  task automatic test_pause_until_empty();
    write_reg(REG_EXP_WIDTH, 6'd8);
    write_reg(REG_FRAC_WIDTH, 6'd23);
    set_idling(3);
    repeat (50) send_value(random_double());
    drain();
    repeat (50) send_value(random_double());
    drain();
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (out_tvalid && out_tready) begin
      got = res_t'(out_tdata[64:0]);
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_q.pop_front();
        if (got.sign !== want.sign) begin
          $display("%0t: sign exp %b got %b", $time, want.sign, got.sign);
          error_count++;
        end
        if (got.exp_field !== want.exp_field) begin
          $display("%0t: exp_field exp %h got %h", $time, want.exp_field, got.exp_field);
          error_count++;
        end
        if (got.frac_field !== want.frac_field) begin
          $display("%0t: frac_field exp %h got %h", $time, want.frac_field, got.frac_field);
          error_count++;
        end
        if (got.overflow !== want.overflow) begin
          $display("%0t: overflow exp %b got %b", $time, want.overflow, got.overflow);
          error_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    error_count  = 0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_cycles  = 0;
    cur_exp_w    = 4'd8;
    cur_frac_w   = 6'd23;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_format();
    test_width_settings();
    test_output_hold_off();
    test_pause_until_empty();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: double_to_custom_float_unit.f
rtl/dtcf_pkg.sv
rtl/dtcf_decode.sv
rtl/dtcf_align.sv
rtl/dtcf_round.sv
rtl/double_to_custom_float_unit.sv
sim/tb_double_to_custom_float_unit.sv
